FILE: rtl/core/gds_pkg.sv
// Shared types, constants, microprogram and calendar helpers of the date unit.
`default_nettype none

package gds_pkg;

	localparam int BASE_YEAR_DEF = 1900;
	localparam int YEAR_SPAN_DEF = 256;

	localparam int OP_W   = 3;
	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 12;
	localparam int SER_W  = 17;
	localparam int WD_W   = 3;
	localparam int PC_W   = 4;

	typedef enum logic [OP_W-1:0] {
		OP_TO_SERIAL   = 3'd0,
		OP_FROM_SERIAL = 3'd1,
		OP_ADD         = 3'd2,
		OP_SUB         = 3'd3,
		OP_WEEKDAY     = 3'd4,
		OP_VALIDATE    = 3'd5
	} opcode_t;

	typedef enum logic [3:0] {
		A_NOP,
		A_LOAD,
		A_YEAR_FWD,
		A_MONTH_FWD,
		A_ADD_DAY,
		A_SHIFT,
		A_INV_INIT,
		A_YEAR_INV,
		A_MONTH_INV,
		A_SET_DAY,
		A_OUT_OK,
		A_OUT_BAD
	} act_t;

	typedef enum logic [2:0] {
		M_WAIT_IN,
		M_NEXT,
		M_BRANCH,
		M_REPEAT,
		M_WAIT_OUT
	} mode_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_SER_BAD,
		C_OP_SERIAL,
		C_PRE_BAD,
		C_YEAR_MATCH,
		C_MONTH_MATCH,
		C_DAY_BAD,
		C_OP_KEEP,
		C_SHIFT_BAD,
		C_REM_IN_YEAR,
		C_REM_IN_MONTH
	} cond_t;

	typedef logic [PC_W-1:0] pc_t;

	typedef struct packed {
		act_t  act;
		mode_t mode;
		cond_t cond;
		pc_t   tgt;
	} ucode_t;

	typedef struct packed {
		logic ser_bad;
		logic op_serial;
		logic pre_bad;
		logic year_match;
		logic month_match;
		logic day_bad;
		logic op_keep;
		logic shift_bad;
		logic rem_in_year;
		logic rem_in_month;
		logic out_free;
	} dp_status_t;

	typedef struct packed {
		act_t act;
		logic en;
	} dp_ctl_t;

	// Labeled steps of the microprogram.
	localparam pc_t P_IDLE     = 4'd0;
	localparam pc_t P_CHK_SER  = 4'd1;
	localparam pc_t P_IS_SER   = 4'd2;
	localparam pc_t P_CHK_DATE = 4'd3;
	localparam pc_t P_YEAR_FWD = 4'd4;
	localparam pc_t P_MON_FWD  = 4'd5;
	localparam pc_t P_DAY      = 4'd6;
	localparam pc_t P_KEEP     = 4'd7;
	localparam pc_t P_SHIFT    = 4'd8;
	localparam pc_t P_INV      = 4'd9;
	localparam pc_t P_YEAR_INV = 4'd10;
	localparam pc_t P_MON_INV  = 4'd11;
	localparam pc_t P_SET_DAY  = 4'd12;
	localparam pc_t P_OK       = 4'd13;
	localparam pc_t P_BAD      = 4'd14;

	function automatic ucode_t uc(input act_t a, input mode_t md, input cond_t c, input pc_t t);
		ucode_t w;
		w.act  = a;
		w.mode = md;
		w.cond = c;
		w.tgt  = t;
		return w;
	endfunction

	// A repeat step runs its action and stays until the condition holds, then jumps.
	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		unique case (pc)
			P_IDLE:     w = uc(A_LOAD,      M_WAIT_IN,  C_NONE,         P_CHK_SER);
			P_CHK_SER:  w = uc(A_NOP,       M_BRANCH,   C_SER_BAD,      P_BAD);
			P_IS_SER:   w = uc(A_NOP,       M_BRANCH,   C_OP_SERIAL,    P_INV);
			P_CHK_DATE: w = uc(A_NOP,       M_BRANCH,   C_PRE_BAD,      P_BAD);
			P_YEAR_FWD: w = uc(A_YEAR_FWD,  M_REPEAT,   C_YEAR_MATCH,   P_MON_FWD);
			P_MON_FWD:  w = uc(A_MONTH_FWD, M_REPEAT,   C_MONTH_MATCH,  P_DAY);
			P_DAY:      w = uc(A_ADD_DAY,   M_BRANCH,   C_DAY_BAD,      P_BAD);
			P_KEEP:     w = uc(A_NOP,       M_BRANCH,   C_OP_KEEP,      P_OK);
			P_SHIFT:    w = uc(A_SHIFT,     M_BRANCH,   C_SHIFT_BAD,    P_BAD);
			P_INV:      w = uc(A_INV_INIT,  M_NEXT,     C_NONE,         P_YEAR_INV);
			P_YEAR_INV: w = uc(A_YEAR_INV,  M_REPEAT,   C_REM_IN_YEAR,  P_MON_INV);
			P_MON_INV:  w = uc(A_MONTH_INV, M_REPEAT,   C_REM_IN_MONTH, P_SET_DAY);
			P_SET_DAY:  w = uc(A_SET_DAY,   M_NEXT,     C_NONE,         P_OK);
			P_OK:       w = uc(A_OUT_OK,    M_WAIT_OUT, C_NONE,         P_IDLE);
			P_BAD:      w = uc(A_OUT_BAD,   M_WAIT_OUT, C_NONE,         P_IDLE);
			default:    w = uc(A_NOP,       M_WAIT_OUT, C_NONE,         P_IDLE);
		endcase
		return w;
	endfunction

	// Elaboration-time helpers for span constants.
	function automatic int leaps_upto(input int n);
		return n / 4 - n / 100 + n / 400;
	endfunction

	function automatic int year_start(input int base, input int y);
		return (y - base) * 365 + leaps_upto(y - 1) - leaps_upto(base - 1);
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] n;
		case (m) inside
			4'd2:                    n = 5'd28 + {4'd0, leap};
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			default:                 n = 5'd31;
		endcase
		return n;
	endfunction

	function automatic logic [WD_W-1:0] wd_add(input logic [WD_W-1:0] w, input logic [WD_W-1:0] k);
		logic [WD_W:0] t;
		t = {1'b0, w} + {1'b0, k};
		if (t >= 4'd7)
			t = t - 4'd7;
		return t[WD_W-1:0];
	endfunction

	function automatic logic [WD_W-1:0] mod7_5(input logic [DAY_W-1:0] v);
		logic [DAY_W-1:0] r;
		r = v;
		if (r >= 5'd28)
			r = r - 5'd28;
		else if (r >= 5'd21)
			r = r - 5'd21;
		else if (r >= 5'd14)
			r = r - 5'd14;
		else if (r >= 5'd7)
			r = r - 5'd7;
		return r[WD_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gds_sequencer.sv
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module gds_sequencer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire gds_pkg::dp_status_t status,
	output gds_pkg::dp_ctl_t        ctl
);
	import gds_pkg::*;

	pc_t    pc_q;
	pc_t    pc_next;
	ucode_t cw;
	logic   cond_hit;

	assign cw = ucode_rom(pc_q);

	always_comb begin
		unique case (cw.cond)
			C_NONE:         cond_hit = 1'b0;
			C_SER_BAD:      cond_hit = status.ser_bad;
			C_OP_SERIAL:    cond_hit = status.op_serial;
			C_PRE_BAD:      cond_hit = status.pre_bad;
			C_YEAR_MATCH:   cond_hit = status.year_match;
			C_MONTH_MATCH:  cond_hit = status.month_match;
			C_DAY_BAD:      cond_hit = status.day_bad;
			C_OP_KEEP:      cond_hit = status.op_keep;
			C_SHIFT_BAD:    cond_hit = status.shift_bad;
			C_REM_IN_YEAR:  cond_hit = status.rem_in_year;
			C_REM_IN_MONTH: cond_hit = status.rem_in_month;
			default:        cond_hit = 1'b0;
		endcase
	end

	always_comb begin
		ctl.act  = cw.act;
		ctl.en   = 1'b0;
		pc_next  = pc_q;
		in_ready = 1'b0;
		unique case (cw.mode)
			M_WAIT_IN: begin
				in_ready = 1'b1;
				ctl.en   = in_valid;
				pc_next  = in_valid ? cw.tgt : pc_q;
			end
			M_NEXT: begin
				ctl.en  = 1'b1;
				pc_next = cw.tgt;
			end
			M_BRANCH: begin
				ctl.en  = 1'b1;
				pc_next = cond_hit ? cw.tgt : pc_q + pc_t'(1);
			end
			M_REPEAT: begin
				// The action runs only while the exit condition is still false.
				ctl.en  = !cond_hit;
				pc_next = cond_hit ? cw.tgt : pc_q;
			end
			M_WAIT_OUT: begin
				ctl.en  = status.out_free;
				pc_next = status.out_free ? cw.tgt : pc_q;
			end
			default: begin
				pc_next = P_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= P_IDLE;
		else
			pc_q <= pc_next;
	end

endmodule

`default_nettype wire

FILE: rtl/core/gds_datapath.sv
// Calendar datapath: year and month walkers, serial accumulator, weekday and result word.
`default_nettype none

module gds_datapath #(
	parameter int BASE_YEAR = gds_pkg::BASE_YEAR_DEF,
	parameter int YEAR_SPAN = gds_pkg::YEAR_SPAN_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire gds_pkg::dp_ctl_t              ctl,
	input  wire logic [gds_pkg::OP_W-1:0]      operation,
	input  wire logic [gds_pkg::DAY_W-1:0]     day,
	input  wire logic [gds_pkg::MON_W-1:0]     month,
	input  wire logic [gds_pkg::YEAR_W-1:0]    year,
	input  wire logic [gds_pkg::SER_W-1:0]     serial_in,
	input  wire logic [gds_pkg::SER_W-1:0]     day_count,
	output gds_pkg::dp_status_t                status,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [gds_pkg::DAY_W-1:0]          day_out,
	output logic [gds_pkg::MON_W-1:0]          month_out,
	output logic [gds_pkg::YEAR_W-1:0]         year_out,
	output logic [gds_pkg::SER_W-1:0]          serial_out,
	output logic [gds_pkg::WD_W-1:0]           weekday,
	output logic                               valid_res
);
	import gds_pkg::*;

	localparam int MAXS = year_start(BASE_YEAR, BASE_YEAR + YEAR_SPAN);
	localparam int SW   = $clog2(MAXS + (1 << SER_W) + 1);
	localparam int W0   = ((BASE_YEAR - 1601) * 365 + leaps_upto(BASE_YEAR - 1)
	                       - leaps_upto(1600)) % 7;

	localparam logic [SW-1:0]     MAXS_V  = SW'(MAXS);
	localparam logic [YEAR_W-1:0] BASE_V  = YEAR_W'(BASE_YEAR);
	localparam logic [YEAR_W:0]   END_V   = (YEAR_W + 1)'(BASE_YEAR + YEAR_SPAN);
	localparam logic [WD_W-1:0]   W0_V    = WD_W'(W0);
	localparam logic [1:0]        C4_0    = 2'(BASE_YEAR % 4);
	localparam logic [6:0]        C100_0  = 7'(BASE_YEAR % 100);
	localparam logic [8:0]        C400_0  = 9'(BASE_YEAR % 400);

	logic [OP_W-1:0]   op_q;
	logic [DAY_W-1:0]  d_q;
	logic [MON_W-1:0]  m_q;
	logic [YEAR_W-1:0] y_q;
	logic [SER_W-1:0]  cnt_q;
	logic [SW-1:0]     acc_q;
	logic [SW-1:0]     rem_q;
	logic [YEAR_W-1:0] yy_q;
	logic [MON_W-1:0]  mm_q;
	logic [1:0]        c4_q;
	logic [6:0]        c100_q;
	logic [8:0]        c400_q;
	logic [WD_W-1:0]   wd_q;

	logic              out_valid_q;
	logic [DAY_W-1:0]  day_q;
	logic [MON_W-1:0]  month_q;
	logic [YEAR_W-1:0] year_q;
	logic [SER_W-1:0]  serial_q;
	logic [WD_W-1:0]   wdo_q;
	logic              vres_q;

	logic              leap;
	logic [8:0]        year_len;
	logic [DAY_W-1:0]  mdays;
	logic [WD_W-1:0]   year_shift;
	logic [WD_W-1:0]   month_shift;
	logic [SW-1:0]     cnt_ext;
	logic [SW-1:0]     sum;
	logic [SW-1:0]     diff;
	logic [6:0]        c100_inc;
	logic [8:0]        c400_inc;
	logic              out_load;

	// The leap rule comes from running residues, so no division by 100 or 400 is needed.
	assign leap        = (c400_q == 9'd0) || (c4_q == 2'd0 && c100_q != 7'd0);
	assign year_len    = 9'd365 + {8'd0, leap};
	assign mdays       = month_len(mm_q, leap);
	assign year_shift  = 3'd1 + {2'd0, leap};
	assign month_shift = WD_W'(mdays - 5'd28);
	assign cnt_ext     = SW'(cnt_q);
	assign sum         = acc_q + cnt_ext;
	assign diff        = acc_q - cnt_ext;
	assign c100_inc    = (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
	assign c400_inc    = (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
	assign out_load    = ctl.en && (ctl.act == A_OUT_OK || ctl.act == A_OUT_BAD);

	always_comb begin
		status.ser_bad      = (op_q == OP_FROM_SERIAL) && (acc_q == '0 || acc_q > MAXS_V);
		status.op_serial    = (op_q == OP_FROM_SERIAL);
		status.pre_bad      = (op_q > OP_VALIDATE) || (y_q < BASE_V) || ({1'b0, y_q} >= END_V)
		                      || (m_q == 4'd0) || (m_q > 4'd12);
		status.year_match   = (yy_q == y_q);
		status.month_match  = (mm_q == m_q);
		status.day_bad      = (d_q == 5'd0) || (d_q > mdays);
		status.op_keep      = (op_q == OP_TO_SERIAL) || (op_q == OP_WEEKDAY)
		                      || (op_q == OP_VALIDATE);
		status.shift_bad    = (op_q == OP_ADD) ? (sum > MAXS_V) : (cnt_ext >= acc_q);
		status.rem_in_year  = (rem_q <= SW'(year_len));
		status.rem_in_month = (mm_q == 4'd12) || (rem_q <= SW'(mdays));
		status.out_free     = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			case (ctl.act)
				A_LOAD: begin
					op_q   <= operation;
					d_q    <= day;
					m_q    <= month;
					y_q    <= year;
					cnt_q  <= day_count;
					acc_q  <= (operation == OP_FROM_SERIAL) ? SW'(serial_in) : '0;
					yy_q   <= BASE_V;
					c4_q   <= C4_0;
					c100_q <= C100_0;
					c400_q <= C400_0;
					mm_q   <= 4'd1;
					wd_q   <= W0_V;
				end
				A_YEAR_FWD: begin
					acc_q  <= acc_q + SW'(year_len);
					yy_q   <= yy_q + 12'd1;
					c4_q   <= c4_q + 2'd1;
					c100_q <= c100_inc;
					c400_q <= c400_inc;
					wd_q   <= wd_add(wd_q, year_shift);
				end
				A_MONTH_FWD: begin
					acc_q <= acc_q + SW'(mdays);
					mm_q  <= mm_q + 4'd1;
					wd_q  <= wd_add(wd_q, month_shift);
				end
				A_ADD_DAY: begin
					acc_q <= acc_q + SW'(d_q);
					rem_q <= SW'(d_q);
					wd_q  <= wd_add(wd_q, mod7_5(d_q - 5'd1));
				end
				A_SHIFT: begin
					acc_q <= (op_q == OP_ADD) ? sum : diff;
				end
				A_INV_INIT: begin
					rem_q  <= acc_q;
					yy_q   <= BASE_V;
					c4_q   <= C4_0;
					c100_q <= C100_0;
					c400_q <= C400_0;
					mm_q   <= 4'd1;
					wd_q   <= W0_V;
				end
				A_YEAR_INV: begin
					rem_q  <= rem_q - SW'(year_len);
					yy_q   <= yy_q + 12'd1;
					c4_q   <= c4_q + 2'd1;
					c100_q <= c100_inc;
					c400_q <= c400_inc;
					wd_q   <= wd_add(wd_q, year_shift);
				end
				A_MONTH_INV: begin
					rem_q <= rem_q - SW'(mdays);
					mm_q  <= mm_q + 4'd1;
					wd_q  <= wd_add(wd_q, month_shift);
				end
				A_SET_DAY: begin
					wd_q <= wd_add(wd_q, mod7_5(rem_q[DAY_W-1:0] - 5'd1));
				end
				default: begin
				end
			endcase
		end
	end

	// Result word; the walkers already hold the date of the serial in acc_q.
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (ctl.act == A_OUT_OK) begin
				day_q    <= rem_q[DAY_W-1:0];
				month_q  <= mm_q;
				year_q   <= yy_q;
				serial_q <= acc_q[SER_W-1:0];
				wdo_q    <= wd_q;
				vres_q   <= 1'b1;
			end else begin
				day_q    <= '0;
				month_q  <= '0;
				year_q   <= '0;
				serial_q <= '0;
				wdo_q    <= '0;
				vres_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid  = out_valid_q;
	assign day_out    = day_q;
	assign month_out  = month_q;
	assign year_out   = year_q;
	assign serial_out = serial_q;
	assign weekday    = wdo_q;
	assign valid_res  = vres_q;

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> status.out_free)
		else $error("result word overwritten before it was taken");

	a_valid_date_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && vres_q |-> month_q >= 4'd1 && month_q <= 4'd12 && day_q != 5'd0)
		else $error("valid result carries an impossible date");

	a_invalid_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !vres_q |-> serial_q == '0 && year_q == '0 && wdo_q == '0)
		else $error("invalid result is not cleared");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> wdo_q < 3'd7)
		else $error("weekday out of range");

endmodule

`default_nettype wire

FILE: rtl/core/gregorian_date_serial_unit.sv
// Top level of the Gregorian date unit: sequencer and calendar datapath.
//
//  channel  direction  handshake              word
//  in       sink       in_valid / in_ready    operation, day, month, year, serial_in, day_count
//  out      source     out_valid / out_ready  day_out, month_out, year_out, serial_out,
//                                             weekday, valid_res
//
// One word is in work at a time; each cycle runs one control word of the microprogram.
// A date walk steps from January of BASE_YEAR through the years and then the months,
// one year or month per cycle. Conversions and checks make one walk; add and subtract
// make two, a forward walk and an inverse walk.
// The input is ready again in the cycle after the result is loaded into the output register.
// Reset clears the step counter and the output valid flag; a stalled output holds the
// sequencer at its final step.
`default_nettype none

module gregorian_date_serial_unit #(
	parameter int BASE_YEAR = gds_pkg::BASE_YEAR_DEF,
	parameter int YEAR_SPAN = gds_pkg::YEAR_SPAN_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [gds_pkg::OP_W-1:0]      operation,
	input  wire logic [gds_pkg::DAY_W-1:0]     day,
	input  wire logic [gds_pkg::MON_W-1:0]     month,
	input  wire logic [gds_pkg::YEAR_W-1:0]    year,
	input  wire logic [gds_pkg::SER_W-1:0]     serial_in,
	input  wire logic [gds_pkg::SER_W-1:0]     day_count,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [gds_pkg::DAY_W-1:0]          day_out,
	output logic [gds_pkg::MON_W-1:0]          month_out,
	output logic [gds_pkg::YEAR_W-1:0]         year_out,
	output logic [gds_pkg::SER_W-1:0]          serial_out,
	output logic [gds_pkg::WD_W-1:0]           weekday,
	output logic                               valid_res
);
	import gds_pkg::*;

	dp_status_t status;
	dp_ctl_t    ctl;

	gds_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.ctl      (ctl)
	);

	gds_datapath #(
		.BASE_YEAR (BASE_YEAR),
		.YEAR_SPAN (YEAR_SPAN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.operation  (operation),
		.day        (day),
		.month      (month),
		.year       (year),
		.serial_in  (serial_in),
		.day_count  (day_count),
		.status     (status),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.day_out    (day_out),
		.month_out  (month_out),
		.year_out   (year_out),
		.serial_out (serial_out),
		.weekday    (weekday),
		.valid_res  (valid_res)
	);

endmodule

`default_nettype wire
